@@ rtl/reprojection_residual_with_point_unit_assert.svh @@
// Assertion macros for the reprojection residual unit.
// Included by the RTL modules that carry concurrent checks; needs aclk and aresetn in scope.
`ifndef REPROJECTION_RESIDUAL_WITH_POINT_UNIT_ASSERT_SVH
`define REPROJECTION_RESIDUAL_WITH_POINT_UNIT_ASSERT_SVH
`ifndef SYNTH
`define RRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define RRP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RRP_ASSERT(lbl, prop, msg)
`define RRP_ASSERT_RST(lbl, prop, msg)
`endif
`endif

@@ rtl/rrp_pkg.sv @@
// Shared widths, register codes and pipeline structs of the reprojection residual unit.
// No dependencies; imported by every RTL module of the unit.
`default_nettype none

package rrp_pkg;

    localparam int VEC_W    = 32;   // Q16.16 vectors, Q2.30 rotation vector
    localparam int COL_W    = 63;   // one packed rotation column
    localparam int ROT_W    = 21;   // one Q2.19 rotation entry
    localparam int ROT_FRAC = 19;
    localparam int W_FRAC   = 30;
    localparam int DIFF_W   = 33;   // point minus centre
    localparam int MROT_W   = ROT_W + DIFF_W;
    localparam int ACC_W    = MROT_W + 2;
    localparam int CROSS_W  = 2 * VEC_W;
    localparam int TERM_W   = CROSS_W - W_FRAC;
    localparam int XYZ_W    = 36;   // camera coordinates after the small rotation
    localparam int MAG_W    = XYZ_W - 1;
    localparam int LO_W     = 28;   // low slice of the weighting product
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 64;

    localparam logic signed [VEC_W-1:0] VEC_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VEC_W-1:0] VEC_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        REG_ROT_X,
        REG_ROT_Y,
        REG_ROT_Z,
        REG_INV_WEIGHT
    } reg_idx_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] obs_u;
        logic signed [VEC_W-1:0] obs_v;
        logic                    neg_u;
        logic                    neg_v;
        logic                    bad;
    } side_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] residual_u;
        logic signed [VEC_W-1:0] residual_v;
        logic                    bad_depth;
    } res_t;

endpackage

`default_nettype wire

@@ rtl/rrp_rot.sv @@
// Seven-stage front end: point minus centre, camera rotation, small-rotation update.
// Depends on rrp_pkg.
`default_nettype none

module rrp_rot
    import rrp_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    adv,
    input  logic                    in_valid,
    input  logic [2:0][VEC_W-1:0]   w_in,
    input  logic [2:0][VEC_W-1:0]   centre_in,
    input  logic [2:0][VEC_W-1:0]   point_in,
    input  logic [VEC_W-1:0]        obs_u_in,
    input  logic [VEC_W-1:0]        obs_v_in,
    input  logic [2:0][COL_W-1:0]   rot_cols,
    output logic                    out_valid,
    output logic signed [XYZ_W-1:0] x_out,
    output logic signed [XYZ_W-1:0] y_out,
    output logic signed [XYZ_W-1:0] z_out,
    output logic [VEC_W-1:0]        obs_u_out,
    output logic [VEC_W-1:0]        obs_v_out
);

    localparam logic signed [ACC_W-1:0]   RND_ROT = ACC_W'(1) << (ROT_FRAC - 1);
    localparam logic signed [CROSS_W-1:0] RND_W   = CROSS_W'(1) << (W_FRAC - 1);

    logic [6:0]                  valid_reg;
    logic [6:0][VEC_W-1:0]       obs_u_reg;
    logic [6:0][VEC_W-1:0]       obs_v_reg;
    logic [3:0][2:0][VEC_W-1:0]  w_reg;
    logic signed [DIFF_W-1:0]    d_reg   [3];
    logic signed [MROT_W-1:0]    m_reg   [3][3];
    logic signed [ACC_W-1:0]     acc_reg [3];
    logic signed [VEC_W-1:0]     p0_reg  [3];
    logic signed [VEC_W-1:0]     p0_d5_reg [3];
    logic signed [VEC_W-1:0]     p0_d6_reg [3];
    logic signed [CROSS_W-1:0]   cp_reg  [6];
    logic signed [TERM_W-1:0]    t_reg   [6];
    logic signed [XYZ_W-1:0]     xyz_reg [3];

    logic signed [VEC_W-1:0]     p0_next [3];
    logic signed [CROSS_W-1:0]   cp_rnd  [6];
    logic [ACC_W-ROT_FRAC-VEC_W:0] acc_top [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc_top[c] = acc_reg[c][ACC_W-1:ROT_FRAC+VEC_W-1];
            if (&acc_top[c] || ~|acc_top[c]) begin
                p0_next[c] = acc_reg[c][ROT_FRAC+VEC_W-1:ROT_FRAC];
            end else begin
                p0_next[c] = acc_reg[c][ACC_W-1] ? VEC_MIN : VEC_MAX;
            end
        end
        for (int i = 0; i < 6; i++) begin
            cp_rnd[i] = cp_reg[i] + RND_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            obs_u_reg <= {obs_u_reg[5:0], obs_u_in};
            obs_v_reg <= {obs_v_reg[5:0], obs_v_in};
            w_reg     <= {w_reg[2:0], w_in};
            for (int k = 0; k < 3; k++) begin
                d_reg[k] <= $signed({point_in[k][VEC_W-1], point_in[k]})
                          - $signed({centre_in[k][VEC_W-1], centre_in[k]});
            end
            for (int c = 0; c < 3; c++) begin
                for (int r = 0; r < 3; r++) begin
                    m_reg[c][r] <= $signed(rot_cols[c][ROT_W*r +: ROT_W]) * d_reg[r];
                end
                acc_reg[c]   <= m_reg[c][0] + m_reg[c][1] + m_reg[c][2] + RND_ROT;
                p0_reg[c]    <= p0_next[c];
                p0_d5_reg[c] <= p0_reg[c];
                p0_d6_reg[c] <= p0_d5_reg[c];
            end
            // Cross terms of W x P0, w_reg[3] lines up with p0_reg.
            cp_reg[0] <= $signed(w_reg[3][1]) * p0_reg[2];
            cp_reg[1] <= $signed(w_reg[3][2]) * p0_reg[1];
            cp_reg[2] <= $signed(w_reg[3][2]) * p0_reg[0];
            cp_reg[3] <= $signed(w_reg[3][0]) * p0_reg[2];
            cp_reg[4] <= $signed(w_reg[3][0]) * p0_reg[1];
            cp_reg[5] <= $signed(w_reg[3][1]) * p0_reg[0];
            for (int i = 0; i < 6; i++) begin
                t_reg[i] <= cp_rnd[i][CROSS_W-1:W_FRAC];
            end
            xyz_reg[0] <= p0_d6_reg[0] + t_reg[0] - t_reg[1];
            xyz_reg[1] <= p0_d6_reg[1] + t_reg[2] - t_reg[3];
            xyz_reg[2] <= p0_d6_reg[2] + t_reg[4] - t_reg[5];
        end
    end

    assign out_valid = valid_reg[6];
    assign x_out     = xyz_reg[0];
    assign y_out     = xyz_reg[1];
    assign z_out     = xyz_reg[2];
    assign obs_u_out = obs_u_reg[6];
    assign obs_v_out = obs_v_reg[6];

endmodule

`default_nettype wire

@@ rtl/rrp_div.sv @@
// Pipelined restoring divider: |x| and |y| scaled by 2^FRAC_BITS over the depth, one bit per stage.
// Depends on rrp_pkg.
`default_nettype none

module rrp_div
    import rrp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic signed [XYZ_W-1:0]             x_in,
    input  logic signed [XYZ_W-1:0]             y_in,
    input  logic signed [XYZ_W-1:0]             z_in,
    input  logic [VEC_W-1:0]                    obs_u_in,
    input  logic [VEC_W-1:0]                    obs_v_in,
    output logic                                out_valid,
    output logic [MAG_W+FRAC_BITS-1:0]          q_u_out,
    output logic [MAG_W+FRAC_BITS-1:0]          q_v_out,
    output side_t                               side_out
);

    localparam int NB = MAG_W + FRAC_BITS;

    logic              valid_reg [0:NB];
    logic [NB-1:0]     num_reg   [0:NB][2];
    logic [MAG_W-1:0]  rem_reg   [0:NB][2];
    logic [MAG_W-1:0]  div_reg   [0:NB];
    side_t             side_reg  [0:NB];

    logic signed [XYZ_W-1:0] abs_x;
    logic signed [XYZ_W-1:0] abs_y;
    logic [MAG_W:0]          trial [NB][2];
    logic [MAG_W:0]          diff  [NB][2];
    logic                    ge    [NB][2];

    always_comb begin
        abs_x = x_in[XYZ_W-1] ? -x_in : x_in;
        abs_y = y_in[XYZ_W-1] ? -y_in : y_in;
        for (int k = 0; k < NB; k++) begin
            for (int l = 0; l < 2; l++) begin
                trial[k][l] = {rem_reg[k][l], num_reg[k][l][NB-1]};
                diff[k][l]  = trial[k][l] - {1'b0, div_reg[k]};
                ge[k][l]    = trial[k][l] >= {1'b0, div_reg[k]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= NB; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < NB; k++) begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            num_reg[0][0] <= {abs_x[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            num_reg[0][1] <= {abs_y[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            rem_reg[0][0] <= '0;
            rem_reg[0][1] <= '0;
            div_reg[0]    <= z_in[MAG_W-1:0];
            side_reg[0]   <= '{obs_u: obs_u_in, obs_v: obs_v_in,
                               neg_u: x_in[XYZ_W-1], neg_v: y_in[XYZ_W-1],
                               bad: z_in[XYZ_W-1] || (z_in == '0)};
            // Quotient bits shift in at the bottom while numerator bits leave at the top.
            for (int k = 0; k < NB; k++) begin
                for (int l = 0; l < 2; l++) begin
                    num_reg[k+1][l] <= {num_reg[k][l][NB-2:0], ge[k][l]};
                    rem_reg[k+1][l] <= ge[k][l] ? diff[k][l][MAG_W-1:0]
                                                : trial[k][l][MAG_W-1:0];
                end
                div_reg[k+1]  <= div_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[NB];
    assign q_u_out   = num_reg[NB][0];
    assign q_v_out   = num_reg[NB][1];
    assign side_out  = side_reg[NB];

endmodule

`default_nettype wire

@@ rtl/rrp_weigh.sv @@
// Five-stage back end: sign, subtract observation, clamp, weight multiply, round and saturate.
// Depends on rrp_pkg.
`default_nettype none

module rrp_weigh
    import rrp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [MAG_W+FRAC_BITS-1:0]  q_u_in,
    input  logic [MAG_W+FRAC_BITS-1:0]  q_v_in,
    input  side_t                       side_in,
    input  logic [VEC_W-1:0]            inv_weight,
    output logic                        out_valid,
    output res_t                        res_out
);

    localparam int NB     = MAG_W + FRAC_BITS;
    localparam int QW     = NB + 1;
    localparam int DW2    = NB + 2;
    localparam int CW     = VEC_W + 1 + FRAC_BITS;   // clamp width, saturation unaffected
    localparam int HI_W   = CW - LO_W;
    localparam int PROD_W = CW + VEC_W + 1;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

    logic [4:0]                   valid_reg;
    side_t                        side_reg [4];
    logic signed [QW-1:0]         q_reg    [2];
    logic signed [CW-1:0]         dd_reg   [2];
    logic [LO_W+VEC_W-1:0]        pl_reg   [2];
    logic signed [HI_W+VEC_W:0]   ph_reg   [2];
    logic signed [PROD_W-1:0]     sum_reg  [2];
    res_t                         res_reg;

    logic [NB-1:0]                q_mag    [2];
    logic                         q_neg    [2];
    logic [VEC_W-1:0]             obs      [2];
    logic signed [DW2-1:0]        dfull    [2];
    logic [DW2-CW:0]              d_top    [2];
    logic signed [CW-1:0]         dd_next  [2];
    logic [SH_W-1:0]              sh       [2];
    logic [SH_W-VEC_W:0]          sh_top   [2];
    logic signed [VEC_W-1:0]      sat_next [2];

    always_comb begin
        q_mag[0] = q_u_in;
        q_mag[1] = q_v_in;
        q_neg[0] = side_in.neg_u;
        q_neg[1] = side_in.neg_v;
        obs[0]   = side_reg[0].obs_u;
        obs[1]   = side_reg[0].obs_v;
        for (int l = 0; l < 2; l++) begin
            dfull[l] = $signed({q_reg[l][QW-1], q_reg[l]})
                     - $signed({{(DW2-VEC_W){obs[l][VEC_W-1]}}, obs[l]});
            d_top[l] = dfull[l][DW2-1:CW-1];
            if (&d_top[l] || ~|d_top[l]) begin
                dd_next[l] = dfull[l][CW-1:0];
            end else begin
                dd_next[l] = dfull[l][DW2-1] ? $signed({1'b1, {(CW-1){1'b0}}})
                                             : $signed({1'b0, {(CW-1){1'b1}}});
            end
            sh[l]     = sum_reg[l][PROD_W-1:FRAC_BITS];
            sh_top[l] = sh[l][SH_W-1:VEC_W-1];
            if (&sh_top[l] || ~|sh_top[l]) begin
                sat_next[l] = sh[l][VEC_W-1:0];
            end else begin
                sat_next[l] = sh[l][SH_W-1] ? VEC_MIN : VEC_MAX;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_in;
            for (int s = 1; s < 4; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
            for (int l = 0; l < 2; l++) begin
                q_reg[l]   <= q_neg[l] ? -$signed({1'b0, q_mag[l]}) : $signed({1'b0, q_mag[l]});
                dd_reg[l]  <= dd_next[l];
                pl_reg[l]  <= dd_reg[l][LO_W-1:0] * inv_weight;
                ph_reg[l]  <= $signed(dd_reg[l][CW-1:LO_W]) * $signed({1'b0, inv_weight});
                sum_reg[l] <= $signed({ph_reg[l], {LO_W{1'b0}}})
                            + $signed({{(PROD_W-LO_W-VEC_W){1'b0}}, pl_reg[l]}) + RND;
            end
            res_reg.residual_u <= side_reg[3].bad ? VEC_MAX : sat_next[0];
            res_reg.residual_v <= side_reg[3].bad ? VEC_MAX : sat_next[1];
            res_reg.bad_depth  <= side_reg[3].bad;
        end
    end

    assign out_valid = valid_reg[4];
    assign res_out   = res_reg;

endmodule

`default_nettype wire

@@ rtl/reprojection_residual_with_point_unit.sv @@
// Top level of the reprojection residual unit: register port, pipeline and output skid buffer.
// Depends on rrp_pkg, rrp_rot, rrp_div, rrp_weigh and the assertion macro header.
//
//  channel  | handshake          | payload
//  ---------+--------------------+----------------------------------------------------
//  s_       | s_valid / s_ready  | rot_vec, centre, point (x, y, z), observed_u/v
//  m_       | m_valid / m_ready  | residual_u, residual_v, bad_depth
//  APB      | psel/penable/pready| rotation columns at 0x00/0x08/0x10, inv_weight 0x18
//
// One transaction per cycle is accepted while the skid register is empty; data pass through
// seven rotation stages, then the one-bit-per-stage divider, then five weighting
// stages. Reset is synchronous and clears all valid bits; registers return
// to identity-free zero columns and a unit weight (1.0 in Q16.16). When m_ready drops, one more
// transaction lands in the skid register and then the whole pipeline holds.
`default_nettype none
`include "reprojection_residual_with_point_unit_assert.svh"

module reprojection_residual_with_point_unit
    import rrp_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VEC_W-1:0] s_rot_vec_x,
    input  logic signed [VEC_W-1:0] s_rot_vec_y,
    input  logic signed [VEC_W-1:0] s_rot_vec_z,
    input  logic signed [VEC_W-1:0] s_centre_x,
    input  logic signed [VEC_W-1:0] s_centre_y,
    input  logic signed [VEC_W-1:0] s_centre_z,
    input  logic signed [VEC_W-1:0] s_point_x,
    input  logic signed [VEC_W-1:0] s_point_y,
    input  logic signed [VEC_W-1:0] s_point_z,
    input  logic signed [VEC_W-1:0] s_observed_u,
    input  logic signed [VEC_W-1:0] s_observed_v,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VEC_W-1:0] m_residual_u,
    output logic signed [VEC_W-1:0] m_residual_v,
    output logic                    m_bad_depth,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    localparam int NB = MAG_W + FRAC_BITS;

    logic [COL_W-1:0] rot_col_x_reg;
    logic [COL_W-1:0] rot_col_y_reg;
    logic [COL_W-1:0] rot_col_z_reg;
    logic [VEC_W-1:0] inv_weight_reg;
    reg_idx_t         reg_idx;

    logic                    adv;
    logic                    rot_valid;
    logic signed [XYZ_W-1:0] rot_x;
    logic signed [XYZ_W-1:0] rot_y;
    logic signed [XYZ_W-1:0] rot_z;
    logic [VEC_W-1:0]        rot_obs_u;
    logic [VEC_W-1:0]        rot_obs_v;
    logic                    div_valid;
    logic [NB-1:0]           div_q_u;
    logic [NB-1:0]           div_q_v;
    side_t                   div_side;
    logic                    pipe_valid;
    res_t                    pipe_res;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;

    // Register port.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rot_col_x_reg  <= '0;
            rot_col_y_reg  <= '0;
            rot_col_z_reg  <= '0;
            inv_weight_reg <= VEC_W'(65536);
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_ROT_X:      rot_col_x_reg  <= pwdata[COL_W-1:0];
                REG_ROT_Y:      rot_col_y_reg  <= pwdata[COL_W-1:0];
                REG_ROT_Z:      rot_col_z_reg  <= pwdata[COL_W-1:0];
                REG_INV_WEIGHT: inv_weight_reg <= pwdata[VEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROT_X:      prdata = {1'b0, rot_col_x_reg};
            REG_ROT_Y:      prdata = {1'b0, rot_col_y_reg};
            REG_ROT_Z:      prdata = {1'b0, rot_col_z_reg};
            REG_INV_WEIGHT: prdata = {{(DATA_W-VEC_W){1'b0}}, inv_weight_reg};
            default:        prdata = '0;
        endcase
    end

    // The pipeline moves whenever the skid register is free.
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    rrp_rot u_rot (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .w_in      ({s_rot_vec_z, s_rot_vec_y, s_rot_vec_x}),
        .centre_in ({s_centre_z, s_centre_y, s_centre_x}),
        .point_in  ({s_point_z, s_point_y, s_point_x}),
        .obs_u_in  (s_observed_u),
        .obs_v_in  (s_observed_v),
        .rot_cols  ({rot_col_z_reg, rot_col_y_reg, rot_col_x_reg}),
        .out_valid (rot_valid),
        .x_out     (rot_x),
        .y_out     (rot_y),
        .z_out     (rot_z),
        .obs_u_out (rot_obs_u),
        .obs_v_out (rot_obs_v)
    );

    rrp_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rot_valid),
        .x_in      (rot_x),
        .y_in      (rot_y),
        .z_in      (rot_z),
        .obs_u_in  (rot_obs_u),
        .obs_v_in  (rot_obs_v),
        .out_valid (div_valid),
        .q_u_out   (div_q_u),
        .q_v_out   (div_q_v),
        .side_out  (div_side)
    );

    rrp_weigh #(
        .FRAC_BITS (FRAC_BITS)
    ) u_weigh (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (div_valid),
        .q_u_in     (div_q_u),
        .q_v_in     (div_q_v),
        .side_in    (div_side),
        .inv_weight (inv_weight_reg),
        .out_valid  (pipe_valid),
        .res_out    (pipe_res)
    );

    // Output register with a one-entry skid behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (skid_valid_reg) begin
                if (m_ready) begin
                    skid_valid_reg <= 1'b0;
                end
            end else if (pipe_valid) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else begin
                if (m_ready) begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (pipe_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= pipe_res;
            end else begin
                skid_reg <= pipe_res;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_residual_u = out_reg.residual_u;
    assign m_residual_v = out_reg.residual_v;
    assign m_bad_depth  = out_reg.bad_depth;

    `RRP_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full with empty output")
    `RRP_ASSERT(a_skid_holds, (skid_valid_reg && !m_ready) |=> skid_valid_reg, "skid transaction lost")
    `RRP_ASSERT(a_drain, (out_valid_reg && m_ready && !skid_valid_reg && !pipe_valid) |=> !out_valid_reg, "stale output repeated")
    `RRP_ASSERT(a_bad_sat, (out_valid_reg && m_bad_depth) |-> (m_residual_u == VEC_MAX && m_residual_v == VEC_MAX), "bad depth without saturation")
    `RRP_ASSERT_RST(a_reset_clears, !aresetn |=> (!out_valid_reg && !skid_valid_reg), "reset left a transaction")

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench of the reprojection residual unit.
// Needs rrp_pkg and reprojection_residual_with_point_unit; predicts each residual in place.
`timescale 1ns / 100ps

module tb_top;
    import rrp_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 49 + FRAC;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 240;

    typedef struct packed {
        logic signed [31:0] wx, wy, wz;
        logic signed [31:0] cx, cy, cz;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] ou, ov;
    } observation_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    logic signed [31:0] s_rot_vec_x = 0, s_rot_vec_y = 0, s_rot_vec_z = 0;
    logic signed [31:0] s_centre_x = 0, s_centre_y = 0, s_centre_z = 0;
    logic signed [31:0] s_point_x = 0, s_point_y = 0, s_point_z = 0;
    logic signed [31:0] s_observed_u = 0, s_observed_v = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [31:0] m_residual_u, m_residual_v;
    logic m_bad_depth;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [DATA_W-1:0] pwdata = 0;
    logic [DATA_W-1:0] prdata;
    logic pready;

    reprojection_residual_with_point_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 aclk = ~aclk;

    // Shadow copy of the camera registers.
    logic [62:0] rot_col [3];
    logic [31:0] weight_q;

    observation_t pending_obs[$];
    res_t expected_res[$];
    observation_t driven_obs;
    int idle_pct = 0;
    int stall_pct = 0;
    bit failed = 0;
    int cycle_count = 0;

    function automatic longint sat32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint rnd_shift(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint weigh_residual(input longint d);
        longint unsigned m, w, bound;
        longint p;
        w = weight_q;
        m = (d < 0) ? longint'(-d) : longint'(d);
        bound = 64'd1 << (33 + FRAC);
        if (m == 0 || w == 0) return 0;
        if (w > bound / m) return (d < 0) ? -64'sd2147483648 : 64'sd2147483647;
        p = longint'(m * w);
        if (d < 0) p = -p;
        return sat32(rnd_shift(p, FRAC));
    endfunction

    function automatic res_t predict_residual(input observation_t o);
        longint d [3];
        longint cam [3];
        longint acc, x, y, z, wx, wy, wz;
        res_t r;
        d[0] = longint'(o.px) - longint'(o.cx);
        d[1] = longint'(o.py) - longint'(o.cy);
        d[2] = longint'(o.pz) - longint'(o.cz);
        for (int c = 0; c < 3; c++) begin
            acc = 0;
            for (int k = 0; k < 3; k++)
                acc += longint'($signed(rot_col[c][21*k +: 21])) * d[k];
            cam[c] = sat32(rnd_shift(acc, ROT_FRAC));
        end
        wx = o.wx; wy = o.wy; wz = o.wz;
        x = cam[0] + rnd_shift(wy * cam[2], W_FRAC) - rnd_shift(wz * cam[1], W_FRAC);
        y = cam[1] + rnd_shift(wz * cam[0], W_FRAC) - rnd_shift(wx * cam[2], W_FRAC);
        z = cam[2] + rnd_shift(wx * cam[1], W_FRAC) - rnd_shift(wy * cam[0], W_FRAC);
        if (z <= 0) begin
            r.residual_u = VEC_MAX;
            r.residual_v = VEC_MAX;
            r.bad_depth = 1'b1;
        end else begin
            r.residual_u = 32'(weigh_residual((x * (64'sd1 <<< FRAC)) / z - longint'(o.ou)));
            r.residual_v = 32'(weigh_residual((y * (64'sd1 <<< FRAC)) / z - longint'(o.ov)));
            r.bad_depth = 1'b0;
        end
        return r;
    endfunction

    // Driver: a held transaction stays put until the unit takes it.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) expected_res.push_back(predict_residual(driven_obs));
            if (pending_obs.size() > 0 && $urandom_range(99) >= idle_pct) begin
                driven_obs = pending_obs.pop_front();
                s_rot_vec_x <= driven_obs.wx; s_rot_vec_y <= driven_obs.wy;
                s_rot_vec_z <= driven_obs.wz;
                s_centre_x <= driven_obs.cx; s_centre_y <= driven_obs.cy;
                s_centre_z <= driven_obs.cz;
                s_point_x <= driven_obs.px; s_point_y <= driven_obs.py;
                s_point_z <= driven_obs.pz;
                s_observed_u <= driven_obs.ou; s_observed_v <= driven_obs.ov;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor and random backpressure.
    always @(posedge aclk) begin
        res_t e;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        m_ready <= aresetn && ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_res.size() == 0) begin
                $display("%0t: unexpected result u=%h v=%h bad=%b", $time,
                         m_residual_u, m_residual_v, m_bad_depth);
                failed = 1;
            end else begin
                e = expected_res.pop_front();
                if (m_residual_u !== e.residual_u) begin
                    $display("%0t: residual_u expected %h actual %h", $time,
                             e.residual_u, m_residual_u);
                    failed = 1;
                end
                if (m_residual_v !== e.residual_v) begin
                    $display("%0t: residual_v expected %h actual %h", $time,
                             e.residual_v, m_residual_v);
                    failed = 1;
                end
                if (m_bad_depth !== e.bad_depth) begin
                    $display("%0t: bad_depth expected %b actual %b", $time,
                             e.bad_depth, m_bad_depth);
                    failed = 1;
                end
            end
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 3;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_INV_WEIGHT) weight_q = value[31:0];
        else rot_col[idx] = value[62:0];
    endtask

    task automatic drain();
        do @(negedge aclk);
        while (pending_obs.size() > 0 || s_valid || expected_res.size() > 0);
        repeat (LATENCY + 5) @(negedge aclk);
    endtask

    function automatic logic [62:0] pack_column(input int a, input int b, input int c);
        return {c[20:0], b[20:0], a[20:0]};
    endfunction

    function automatic logic [62:0] rand_col();
        return 63'({$urandom, $urandom});
    endfunction

    // Mostly a camera near identity looking at points ahead of it, with
    // modest small-rotation updates; the rest is raw noise over all bits.
    function automatic observation_t make_obs(input bit plausible);
        observation_t o;
        o = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom};
        if (plausible) begin
            o.wx = $signed($urandom_range(1 << 25)) - (1 << 24);
            o.wy = $signed($urandom_range(1 << 25)) - (1 << 24);
            o.wz = $signed($urandom_range(1 << 25)) - (1 << 24);
            o.cx = $signed($urandom_range(1 << 22)) - (1 << 21);
            o.cy = $signed($urandom_range(1 << 22)) - (1 << 21);
            o.cz = $signed($urandom_range(1 << 22)) - (1 << 21);
            o.px = $signed($urandom_range(1 << 24)) - (1 << 23);
            o.py = $signed($urandom_range(1 << 24)) - (1 << 23);
            o.pz = o.cz + $signed($urandom_range(1 << 24, 1 << 16));
            o.ou = $signed($urandom_range(1 << 18)) - (1 << 17);
            o.ov = $signed($urandom_range(1 << 18)) - (1 << 17);
        end
        return o;
    endfunction

    localparam int ONE = 1 << 19;

    initial begin
        observation_t o;
        rot_col[0] = 0; rot_col[1] = 0; rot_col[2] = 0;
        weight_q = 32'd65536;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(REG_ROT_X, pack_column(ONE, 0, 0));
        write_reg(REG_ROT_Y, pack_column(0, ONE, 0));
        write_reg(REG_ROT_Z, pack_column(0, 0, ONE));

        // Directed: field extremes, point at the centre (zero depth),
        // point behind the camera, and huge quotients.
        o = '0; pending_obs.push_back(o);
        o.pz = 32'sd65536; pending_obs.push_back(o);
        o.pz = -32'sd65536; pending_obs.push_back(o);
        o = '1; pending_obs.push_back(o);
        o = {11{32'h7FFF_FFFF}}; pending_obs.push_back(o);
        o = {11{32'h8000_0000}}; pending_obs.push_back(o);
        o = '0; o.pz = 32'sd1; o.px = 32'h7FFF_FFFF; o.cx = 32'h8000_0000;
        pending_obs.push_back(o);
        o.px = 32'h8000_0000; o.cx = 32'h7FFF_FFFF; pending_obs.push_back(o);
        o = '0; o.pz = 32'sd1; o.ou = 32'h8000_0000; o.ov = 32'h7FFF_FFFF;
        pending_obs.push_back(o);
        o = '0; o.pz = 32'sd65536; o.py = 32'sd65536;
        o.wx = 32'h7FFF_FFFF; pending_obs.push_back(o);
        o.wx = 32'h8000_0000; pending_obs.push_back(o);
        o.wy = 32'h7FFF_FFFF; o.wz = 32'h8000_0000; pending_obs.push_back(o);
        for (int i = 0; i < 8; i++) pending_obs.push_back(make_obs(i[0]));
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                1: begin
                    write_reg(REG_ROT_X, pack_column(ONE - 1, 0, 0));
                    write_reg(REG_INV_WEIGHT, 32'd0);
                end
                2: begin
                    write_reg(REG_ROT_X, pack_column(32'h0F_FFFF, 32'h10_0000, 32'h0F_FFFF));
                    write_reg(REG_ROT_Y, pack_column(32'h10_0000, 32'h0F_FFFF, 32'h10_0000));
                    write_reg(REG_ROT_Z, pack_column(32'h0F_FFFF, 32'h0F_FFFF, 32'h0F_FFFF));
                    write_reg(REG_INV_WEIGHT, 32'hFFFF_FFFF);
                end
                3: write_reg(REG_INV_WEIGHT, 32'd1);
                4, 5: begin
                    write_reg(REG_ROT_X, rand_col());
                    write_reg(REG_ROT_Y, rand_col());
                    write_reg(REG_ROT_Z, rand_col());
                    write_reg(REG_INV_WEIGHT, $urandom);
                end
                6: begin
                    write_reg(REG_ROT_X, pack_column(ONE, 0, 0));
                    write_reg(REG_ROT_Y, pack_column(0, ONE, 0));
                    write_reg(REG_ROT_Z, pack_column(0, 0, ONE));
                    write_reg(REG_INV_WEIGHT, $urandom_range(1 << 20));
                end
                7: write_reg(REG_INV_WEIGHT, 32'd65536);
                default: ;
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 53; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 53; end
                default: begin idle_pct = 29; stall_pct = 29; end
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_obs.push_back(make_obs($urandom_range(99) < 75));
            drain();
        end

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
